// ----- design/cnms_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnms_pkg: shared types and constants
// Field widths, the direction code, result item and queue push types, and
// the angle to direction mapping.
// ----------------------------------------------------------------------------
package cnms_pkg;

   localparam int MAG_BITS        = 16;
   localparam int ANGLE_BITS      = 8;
   localparam int ROW_BITS        = 12;
   localparam int COL_BITS        = 10;
   localparam int WIDTH_BITS      = 11;
   localparam int HEIGHT_BITS     = 13;
   localparam int CSR_INDEX_BITS  = 1;
   localparam int CSR_DATA_BITS   = 13;
   localparam int MAX_HEIGHT      = 4096;
   localparam int MIN_SIZE        = 3;
   localparam int WIDTH_RESET     = 640;
   localparam int HEIGHT_RESET    = 480;

   // result queue
   localparam int FIFO_DEPTH      = 16;
   localparam int FIFO_PTR_BITS   = $clog2(FIFO_DEPTH);
   localparam int FIFO_CNT_BITS   = FIFO_PTR_BITS + 1;
   localparam int MAX_PUSH        = 3;
   // room for the item in flight and the one being taken
   localparam int FIFO_ACCEPT_MAX = FIFO_DEPTH - 2 * MAX_PUSH;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_FRAME_WIDTH  = 1'b0,
      CSR_FRAME_HEIGHT = 1'b1
   } csr_index_type;

   // neighbour pair along the gradient
   typedef enum logic [1:0] {
      DIR_HORIZ     = 2'd0,   // left / right
      DIR_DIAG_DOWN = 2'd1,   // up-left / down-right
      DIR_VERT      = 2'd2,   // up / down
      DIR_DIAG_UP   = 2'd3    // up-right / down-left
   } dir_type;

   typedef struct packed {
      logic [ROW_BITS-1:0] out_row;
      logic [COL_BITS-1:0] out_col;
      logic [MAG_BITS-1:0] thin_magnitude;
      logic                frame_end;
   } rsp_item_type;

   typedef struct packed {
      logic [1:0]                    count;
      rsp_item_type [MAX_PUSH-1:0]   item;
   } push_type;

   // fold to a half turn, then eight sectors of pi/8
   function automatic dir_type pair_code(input logic [ANGLE_BITS-1:0] angle);
      logic [2:0] sector;
      dir_type    d;
      sector = angle[ANGLE_BITS-2 -: 3];
      case (sector)
         3'd0, 3'd7: d = DIR_HORIZ;
         3'd1, 3'd2: d = DIR_DIAG_DOWN;
         3'd3, 3'd4: d = DIR_VERT;
         default:    d = DIR_DIAG_UP;
      endcase
      return d;
   endfunction

endpackage

// ----- design/cnms_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnms channel interfaces
// Pixel input, result output and register write channels, valid/ready.
// ----------------------------------------------------------------------------
interface cnms_req_if;
   logic                          valid;
   logic                          ready;
   logic [cnms_pkg::MAG_BITS-1:0]   grad_magnitude;
   logic [cnms_pkg::ANGLE_BITS-1:0] grad_angle;
   logic                          frame_start;

   modport source (output valid, grad_magnitude, grad_angle, frame_start, input ready);
   modport sink   (input valid, grad_magnitude, grad_angle, frame_start, output ready);
endinterface

interface cnms_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [cnms_pkg::ROW_BITS-1:0] out_row;
   logic [cnms_pkg::COL_BITS-1:0] out_col;
   logic [cnms_pkg::MAG_BITS-1:0] thin_magnitude;
   logic                          frame_end;

   modport source (output valid, out_row, out_col, thin_magnitude, frame_end, input ready);
   modport sink   (input valid, out_row, out_col, thin_magnitude, frame_end, output ready);
endinterface

interface cnms_csr_if;
   logic                                valid;
   logic                                ready;
   logic [cnms_pkg::CSR_INDEX_BITS-1:0] reg_index;
   logic [cnms_pkg::CSR_DATA_BITS-1:0]  wr_data;

   modport source (output valid, reg_index, wr_data, input ready);
   modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ----- design/cnms_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnms_ram: simple dual-port ram
// One write port, one read port, read data registered.
// ----------------------------------------------------------------------------
module cnms_ram #(
   parameter int WIDTH = 34,
   parameter int DEPTH = 1024
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                 wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic [WIDTH-1:0]                 rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/cnms_rsp_fifo.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cnms_rsp_fifo: result queue
// Takes up to three results a cycle in order, gives one per transfer.
// ----------------------------------------------------------------------------
module cnms_rsp_fifo (
   input  logic                                clock,
   input  logic                                reset,
   input  cnms_pkg::push_type                  push,
   output logic                                out_valid,
   input  logic                                out_ready,
   output cnms_pkg::rsp_item_type              out_item,
   output logic [cnms_pkg::FIFO_CNT_BITS-1:0]  count
);

   cnms_pkg::rsp_item_type                 mem_ff [cnms_pkg::FIFO_DEPTH];
   logic [cnms_pkg::FIFO_PTR_BITS-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [cnms_pkg::FIFO_PTR_BITS-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [cnms_pkg::FIFO_CNT_BITS-1:0]     count_ff, count_in;
   logic                                   pop;

   assign out_valid = (count_ff != '0);
   assign out_item  = mem_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff + cnms_pkg::FIFO_PTR_BITS'(push.count);
      rd_ptr_in = rd_ptr_ff + cnms_pkg::FIFO_PTR_BITS'(pop);
      count_in  = count_ff + cnms_pkg::FIFO_CNT_BITS'(push.count)
                  - cnms_pkg::FIFO_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < cnms_pkg::MAX_PUSH; k++) begin
         if (k < int'(push.count)) begin
            mem_ff[wr_ptr_ff + cnms_pkg::FIFO_PTR_BITS'(k)] <= push.item[k];
         end
      end
   end

endmodule

// ----- design/canny_nonmax_suppression.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// canny_nonmax_suppression: 3x3 non-maximum suppression
// Thins a raster stream of gradient pixels to local maxima along the
// gradient, with row, column and frame-end tags on every result.
// ----------------------------------------------------------------------------
// One pixel is taken per clock while the queue has room. Each pixel costs one
// read and one write of a single line memory (MAX_WIDTH words holding the two
// previous magnitude rows and the direction of the previous row), read on the
// transfer and written back in the next cycle; a forwarding path covers a
// repeated column. Results pass through the compare stage register into a
// 16-entry queue and leave one per transfer, about one row behind the input:
// per row of W pixels the block gives W results (none on the first row, 2W on
// the last row of the frame), so the input stalls only while the queue holds
// more than ten entries. Border pixels give zero. The line memory needs no
// clearing pass after reset.
module canny_nonmax_suppression #(
   parameter int MAX_WIDTH = 1024
) (
   input  logic       clock,
   input  logic       reset,
   cnms_req_if.sink   req_if,
   cnms_rsp_if.source rsp_if,
   cnms_csr_if.sink   csr_if
);

   localparam int AW      = $clog2(MAX_WIDTH > 1 ? MAX_WIDTH : 2);
   localparam int MB      = cnms_pkg::MAG_BITS;
   localparam int RAM_W   = 2 * MB + 2;

   // ---------------------------------------------------------------- config
   // frame sizes are kept clamped and less one
   logic [cnms_pkg::WIDTH_BITS-1:0]  wm1_ff, wm1_in;
   logic [cnms_pkg::HEIGHT_BITS-1:0] hm1_ff, hm1_in;
   logic [cnms_pkg::WIDTH_BITS-1:0]  w_raw, w_clamp;
   logic [cnms_pkg::HEIGHT_BITS-1:0] h_raw, h_clamp;
   logic                             csr_xfer;

   assign csr_if.ready = 1'b1;
   assign csr_xfer     = csr_if.valid;
   assign w_raw        = csr_if.wr_data[cnms_pkg::WIDTH_BITS-1:0];
   assign h_raw        = csr_if.wr_data[cnms_pkg::HEIGHT_BITS-1:0];

   always_comb begin
      if (int'(w_raw) < cnms_pkg::MIN_SIZE) begin
         w_clamp = cnms_pkg::WIDTH_BITS'(cnms_pkg::MIN_SIZE);
      end else if (int'(w_raw) > MAX_WIDTH) begin
         w_clamp = cnms_pkg::WIDTH_BITS'(MAX_WIDTH);
      end else begin
         w_clamp = w_raw;
      end
      if (int'(h_raw) < cnms_pkg::MIN_SIZE) begin
         h_clamp = cnms_pkg::HEIGHT_BITS'(cnms_pkg::MIN_SIZE);
      end else if (int'(h_raw) > cnms_pkg::MAX_HEIGHT) begin
         h_clamp = cnms_pkg::HEIGHT_BITS'(cnms_pkg::MAX_HEIGHT);
      end else begin
         h_clamp = h_raw;
      end
   end

   always_comb begin
      wm1_in = wm1_ff;
      hm1_in = hm1_ff;
      if (csr_xfer) begin
         unique case (cnms_pkg::csr_index_type'(csr_if.reg_index))
            cnms_pkg::CSR_FRAME_WIDTH:  wm1_in = w_clamp - 1'b1;
            cnms_pkg::CSR_FRAME_HEIGHT: hm1_in = h_clamp - 1'b1;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wm1_ff <= cnms_pkg::WIDTH_BITS'(cnms_pkg::WIDTH_RESET - 1);
         hm1_ff <= cnms_pkg::HEIGHT_BITS'(cnms_pkg::HEIGHT_RESET - 1);
      end else begin
         wm1_ff <= wm1_in;
         hm1_ff <= hm1_in;
      end
   end

   // --------------------------------------------------------- input stage
   logic [cnms_pkg::FIFO_CNT_BITS-1:0] fifo_count;
   logic                               req_xfer;
   logic [cnms_pkg::ROW_BITS-1:0]      row_ff, row_in, row_cur;
   logic [cnms_pkg::COL_BITS-1:0]      col_ff, col_in, col_cur;
   logic                               last_col, last_row, in_line;
   logic [31:0]                        col_wide;
   logic [AW-1:0]                      rd_addr;
   cnms_pkg::dir_type                  dir_cur;
   logic                               fwd_hit;

   // the queue must hold whatever the item in flight and this one may push
   assign req_if.ready = (int'(fifo_count) <= cnms_pkg::FIFO_ACCEPT_MAX);
   assign req_xfer     = req_if.valid && req_if.ready;

   assign row_cur  = req_if.frame_start ? '0 : row_ff;
   assign col_cur  = req_if.frame_start ? '0 : col_ff;
   assign last_col = {1'b0, col_cur} >= wm1_ff;
   assign last_row = {1'b0, row_cur} >= hm1_ff;
   assign col_wide = 32'(col_cur);
   assign in_line  = (col_wide < 32'(MAX_WIDTH));
   assign rd_addr  = col_wide[AW-1:0];
   assign dir_cur  = cnms_pkg::pair_code(req_if.grad_angle);

   // position counters, wrapping past a lowered frame size
   always_comb begin
      row_in = row_ff;
      col_in = col_ff;
      if (req_xfer) begin
         if (last_col) begin
            col_in = '0;
            row_in = last_row ? '0 : row_cur + 1'b1;
         end else begin
            col_in = col_cur + 1'b1;
            row_in = row_cur;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff <= '0;
         col_ff <= '0;
      end else begin
         row_ff <= row_in;
         col_ff <= col_in;
      end
   end

   // ------------------------------------------------------ compare stage
   logic                          s1_valid_ff;
   logic [cnms_pkg::ROW_BITS-1:0] s1_row_ff;
   logic [cnms_pkg::COL_BITS-1:0] s1_col_ff;
   logic                          s1_last_col_ff, s1_last_row_ff, s1_inside_ff;
   logic [MB-1:0]                 s1_mag_ff;
   cnms_pkg::dir_type             s1_dir_ff;
   logic [AW-1:0]                 s1_addr_ff;
   logic                          s1_fwd_ff;
   logic [RAM_W-1:0]              fwd_data_ff;

   logic [RAM_W-1:0]              ram_q, line_word, wr_word;
   logic [MB-1:0]                 top_c, mid_c;
   cnms_pkg::dir_type             dir_c;
   logic [MB-1:0]                 win_ff [6];
   cnms_pkg::dir_type             held_dir_ff;
   logic [MB-1:0]                 first_n, second_n, keep_mag;
   logic [cnms_pkg::ROW_BITS-1:0] cr;
   logic [cnms_pkg::COL_BITS-1:0] cc;
   logic                          interior, has_diag, has_edge;
   cnms_pkg::push_type            push;
   cnms_pkg::rsp_item_type        res_diag, res_edge, res_last;

   // same column as the word being written back this cycle
   assign fwd_hit = s1_valid_ff && s1_inside_ff && in_line && (rd_addr == s1_addr_ff);

   cnms_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_WIDTH)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (s1_valid_ff && s1_inside_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_word),
      .rd_en   (req_xfer),
      .rd_addr (rd_addr),
      .rd_data (ram_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= req_xfer;
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         s1_row_ff      <= row_cur;
         s1_col_ff      <= col_cur;
         s1_last_col_ff <= last_col;
         s1_last_row_ff <= last_row;
         s1_inside_ff   <= in_line;
         s1_mag_ff      <= req_if.grad_magnitude;
         s1_dir_ff      <= dir_cur;
         s1_addr_ff     <= rd_addr;
         s1_fwd_ff      <= fwd_hit;
         fwd_data_ff    <= wr_word;
      end
   end

   // line word: upper magnitude, centre magnitude, centre direction
   assign line_word = s1_fwd_ff ? fwd_data_ff : ram_q;
   assign top_c     = s1_inside_ff ? line_word[RAM_W-1 -: MB] : '0;
   assign mid_c     = s1_inside_ff ? line_word[MB+1 -: MB]    : '0;
   assign dir_c     = s1_inside_ff ? cnms_pkg::dir_type'(line_word[1:0])
                                   : cnms_pkg::DIR_HORIZ;
   assign wr_word   = {mid_c, s1_mag_ff, s1_dir_ff};

   // window columns: 0/1 upper row, 2/3 centre row, 4/5 lower row
   always_comb begin
      case (held_dir_ff)
         cnms_pkg::DIR_HORIZ: begin
            first_n  = win_ff[2];
            second_n = mid_c;
         end
         cnms_pkg::DIR_DIAG_DOWN: begin
            first_n  = win_ff[0];
            second_n = s1_mag_ff;
         end
         cnms_pkg::DIR_VERT: begin
            first_n  = win_ff[1];
            second_n = win_ff[5];
         end
         default: begin
            first_n  = top_c;
            second_n = win_ff[4];
         end
      endcase
   end

   assign cr       = s1_row_ff - 1'b1;
   assign cc       = s1_col_ff - 1'b1;
   assign interior = (cr != '0) && (cc != '0) && ({1'b0, cr} < hm1_ff)
                     && ({1'b0, cc} < wm1_ff);
   assign keep_mag = (interior && (win_ff[3] > first_n) && (win_ff[3] >= second_n))
                     ? win_ff[3] : '0;
   assign has_diag = (s1_row_ff != '0) && (s1_col_ff != '0);
   assign has_edge = (s1_row_ff != '0) && s1_last_col_ff;

   always_comb begin
      res_diag = '{out_row: cr, out_col: cc, thin_magnitude: keep_mag, frame_end: 1'b0};
      res_edge = '{out_row: cr, out_col: s1_col_ff, thin_magnitude: '0, frame_end: 1'b0};
      res_last = '{out_row: s1_row_ff, out_col: s1_col_ff, thin_magnitude: '0,
                   frame_end: s1_last_col_ff};
   end

   // pack the results of this pixel in order
   always_comb begin
      push       = '0;
      push.item  = '{res_last, res_last, res_last};
      if (s1_valid_ff) begin
         if (has_diag) begin
            push.item[push.count] = res_diag;
            push.count            = push.count + 1'b1;
         end
         if (has_edge) begin
            push.item[push.count] = res_edge;
            push.count            = push.count + 1'b1;
         end
         if (s1_last_row_ff) begin
            push.item[push.count] = res_last;
            push.count            = push.count + 1'b1;
         end
      end
   end

   // window shift and held direction follow the pixel order
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 6; k++) begin
            win_ff[k] <= '0;
         end
         held_dir_ff <= cnms_pkg::DIR_HORIZ;
      end else if (s1_valid_ff) begin
         win_ff[0]   <= win_ff[1];
         win_ff[1]   <= top_c;
         win_ff[2]   <= win_ff[3];
         win_ff[3]   <= mid_c;
         win_ff[4]   <= win_ff[5];
         win_ff[5]   <= s1_mag_ff;
         held_dir_ff <= dir_c;
      end
   end

   // ------------------------------------------------------- result queue
   cnms_pkg::rsp_item_type rsp_item;

   cnms_rsp_fifo u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .out_valid (rsp_if.valid),
      .out_ready (rsp_if.ready),
      .out_item  (rsp_item),
      .count     (fifo_count)
   );

   assign rsp_if.out_row        = rsp_item.out_row;
   assign rsp_if.out_col        = rsp_item.out_col;
   assign rsp_if.thin_magnitude = rsp_item.thin_magnitude;
   assign rsp_if.frame_end      = rsp_item.frame_end;

endmodule
